@@ hw/rtl/cdta_pkg.sv @@
// cdta_pkg: shared widths, stream packing and status codes for the checked
// divide-then-add block. No dependencies.
`timescale 1ns / 1ps

package cdta_pkg;

  // operand and result width
  localparam int DATA_WIDTH = 32;

  // stream packing, each group padded to whole bytes
  localparam int IN_TDATA_W  = ((3 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int STATUS_W    = 3;

  // result status, first failing check wins
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_DIV_ZERO     = 3'd1,
    ST_DIV_OVERFLOW = 3'd2,
    ST_INEXACT      = 3'd3,
    ST_SUM_OVERFLOW = 3'd4
  } status_t;

endpackage

@@ hw/rtl/checked_divide_then_add_core.sv @@
// checked_divide_then_add_core: pipelined checked signed division followed
// by a checked add. Depends on cdta_pkg.
`timescale 1ns / 1ps

// Each request carries addend, dividend and divisor (signed, DATA_WIDTH bits
// each). The block computes dividend / divisor truncated toward zero, adds
// the addend and returns one result per request: value plus a status code
// (ok, divide by zero, divide overflow, inexact, sum overflow; first failing
// check wins, value is zero on any error). The datapath is a fixed pipeline
// of DATA_WIDTH + 3 register stages: one input stage for magnitudes and
// early checks, one restoring-division stage per quotient bit, one stage for
// quotient sign and exactness, and the output register with the final add.
// A request can enter every cycle while the output is not stalled. Each
// stage holds only while its successor is full and stalled, so bubbles are
// squeezed out and a stalled output still lets upstream stages fill.
module checked_divide_then_add_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // addend [W-1:0], dividend [2W-1:W], divisor [3W-1:2W]
  input  logic [cdta_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // value [W-1:0], zero padded to whole bytes
  output logic [cdta_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status [2:0]
  output logic [cdta_pkg::STATUS_W-1:0]     out_tuser
);

  import cdta_pkg::*;

  localparam int W = DATA_WIDTH;

  // division stage registers, index k holds the state after k quotient bits
  logic            dv_valid_r [0:W];
  logic [W-1:0]    dv_rem_r   [0:W];
  logic [W-1:0]    dv_nq_r    [0:W];
  logic [W-1:0]    dv_dmag_r  [0:W];
  logic [W-1:0]    dv_add_r   [0:W];
  logic            dv_neg_r   [0:W];
  status_t         dv_st_r    [0:W];
  logic            dv_ld      [0:W];

  // sign / exactness stage
  logic            p1_valid_r;
  logic [W-1:0]    p1_q_r;
  logic [W-1:0]    p1_add_r;
  status_t         p1_st_r;
  logic            p1_ld;

  // output register
  logic            out_valid_r;
  logic [W-1:0]    out_value_r;
  status_t         out_st_r;
  logic            out_ld;

  // input stage next values
  logic [W-1:0]    in_addend;
  logic [W-1:0]    in_dividend;
  logic [W-1:0]    in_divisor;
  logic [W-1:0]    in_nmag_nxt;
  logic [W-1:0]    in_dmag_nxt;
  status_t         in_st_nxt;

  // post stage next values
  logic [W-1:0]    p1_q_nxt;
  status_t         p1_st_nxt;
  logic [W-1:0]    out_sum;
  logic            out_ovf;
  logic [W-1:0]    out_value_nxt;
  status_t         out_st_nxt;

  // load enables, a stage moves when it is empty or its successor moves
  assign out_ld = !out_valid_r || out_tready;
  assign p1_ld  = !p1_valid_r || out_ld;
  assign dv_ld[W] = !dv_valid_r[W] || p1_ld;

  genvar gk;
  generate
    for (gk = 0; gk < W; gk++) begin : g_ld
      assign dv_ld[gk] = !dv_valid_r[gk] || dv_ld[gk+1];
    end
  endgenerate

  assign in_tready = dv_ld[0];

  // unpack request and take magnitudes
  assign in_addend   = in_tdata[W-1:0];
  assign in_dividend = in_tdata[2*W-1:W];
  assign in_divisor  = in_tdata[3*W-1:2*W];
  assign in_nmag_nxt = in_dividend[W-1] ? (~in_dividend + 1'b1) : in_dividend;
  assign in_dmag_nxt = in_divisor[W-1]  ? (~in_divisor + 1'b1)  : in_divisor;

  // early checks: zero divisor, then most negative over minus one
  always_comb begin
    if (in_divisor == '0) begin
      in_st_nxt = ST_DIV_ZERO;
    end else if (in_dividend == {1'b1, {(W-1){1'b0}}} && in_divisor == '1) begin
      in_st_nxt = ST_DIV_OVERFLOW;
    end else begin
      in_st_nxt = ST_OK;
    end
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (dv_ld[0]) begin
      dv_valid_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ld[0]) begin
      dv_rem_r[0]  <= '0;
      dv_nq_r[0]   <= in_nmag_nxt;
      dv_dmag_r[0] <= in_dmag_nxt;
      dv_add_r[0]  <= in_addend;
      dv_neg_r[0]  <= in_dividend[W-1] ^ in_divisor[W-1];
      dv_st_r[0]   <= in_st_nxt;
    end
  end

  // one restoring division step per stage: numerator bits shift out of the
  // top of nq while quotient bits shift in at the bottom
  generate
    for (gk = 1; gk <= W; gk++) begin : g_div
      logic         bit_in;
      logic [W+1:0] trial;
      logic         borrow;
      logic [W-1:0] rem_nxt;
      logic [W-1:0] nq_nxt;

      assign bit_in  = dv_nq_r[gk-1][W-1];
      assign trial   = {1'b0, dv_rem_r[gk-1], bit_in} - {2'b00, dv_dmag_r[gk-1]};
      assign borrow  = trial[W+1];
      assign rem_nxt = borrow ? {dv_rem_r[gk-1][W-2:0], bit_in} : trial[W-1:0];
      assign nq_nxt  = {dv_nq_r[gk-1][W-2:0], ~borrow};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_valid_r[gk] <= 1'b0;
        end else if (dv_ld[gk]) begin
          dv_valid_r[gk] <= dv_valid_r[gk-1];
        end
      end

      always_ff @(posedge clk) begin
        if (dv_ld[gk]) begin
          dv_rem_r[gk]  <= rem_nxt;
          dv_nq_r[gk]   <= nq_nxt;
          dv_dmag_r[gk] <= dv_dmag_r[gk-1];
          dv_add_r[gk]  <= dv_add_r[gk-1];
          dv_neg_r[gk]  <= dv_neg_r[gk-1];
          dv_st_r[gk]   <= dv_st_r[gk-1];
        end
      end
    end
  endgenerate

  // apply quotient sign and check exactness
  assign p1_q_nxt = dv_neg_r[W] ? (~dv_nq_r[W] + 1'b1) : dv_nq_r[W];

  always_comb begin
    if (dv_st_r[W] == ST_OK && dv_rem_r[W] != '0) begin
      p1_st_nxt = ST_INEXACT;
    end else begin
      p1_st_nxt = dv_st_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_ld) begin
      p1_valid_r <= dv_valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ld) begin
      p1_q_r   <= p1_q_nxt;
      p1_add_r <= dv_add_r[W];
      p1_st_r  <= p1_st_nxt;
    end
  end

  // final add with signed overflow check, value forced to zero on error
  assign out_sum = p1_add_r + p1_q_r;
  assign out_ovf = (p1_add_r[W-1] == p1_q_r[W-1]) && (out_sum[W-1] != p1_add_r[W-1]);

  always_comb begin
    out_st_nxt    = p1_st_r;
    out_value_nxt = '0;
    if (p1_st_r == ST_OK) begin
      if (out_ovf) begin
        out_st_nxt = ST_SUM_OVERFLOW;
      end else begin
        out_value_nxt = out_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_value_r <= out_value_nxt;
      out_st_r    <= out_st_nxt;
    end
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_value_r);
  assign out_tuser  = out_st_r;

endmodule

@@ test/quotient_sum_checker.sv @@
// quotient_sum_checker: watches both streams of the checked divide-then-add
// core, predicts each result and compares it. Depends on cdta_pkg.
`timescale 1ns / 1ps

module quotient_sum_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // addend, dividend, divisor from the lowest bit up
  input  logic [cdta_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // value, zero padded
  input  logic [cdta_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  input  logic [cdta_pkg::STATUS_W-1:0]    out_tuser,
  output int                               fail_count,
  output int                               results_due
);

  import cdta_pkg::*;

  localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    status_t               status;
  } quotient_sum_t;

  quotient_sum_t awaited_results[$];

  // exact signed divide, then add, with the checks in priority order
  function automatic quotient_sum_t predict_quotient_sum(
    input logic [DATA_WIDTH-1:0] addend,
    input logic [DATA_WIDTH-1:0] dividend,
    input logic [DATA_WIDTH-1:0] divisor
  );
    logic signed [DATA_WIDTH+1:0] a_x;
    logic signed [DATA_WIDTH+1:0] n_x;
    logic signed [DATA_WIDTH+1:0] d_x;
    logic signed [DATA_WIDTH+1:0] q_x;
    logic signed [DATA_WIDTH+1:0] s_x;
    quotient_sum_t r;
    r.value  = '0;
    r.status = ST_OK;
    a_x = $signed(addend);
    n_x = $signed(dividend);
    d_x = $signed(divisor);
    if (divisor == '0) begin
      r.status = ST_DIV_ZERO;
    end else if (dividend == WORD_MIN && divisor == '1) begin
      r.status = ST_DIV_OVERFLOW;
    end else if (n_x % d_x != 0) begin
      r.status = ST_INEXACT;
    end else begin
      q_x = n_x / d_x;
      s_x = a_x + q_x;
      // sum of two in-range words fits one extra bit; overflow if top two differ
      if (s_x[DATA_WIDTH] != s_x[DATA_WIDTH-1]) begin
        r.status = ST_SUM_OVERFLOW;
      end else begin
        r.value = s_x[DATA_WIDTH-1:0];
      end
    end
    return r;
  endfunction

  // compare results first, then queue the prediction for a new request
  always @(posedge clk) begin
    quotient_sum_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: value %0d status %0d",
                 $signed(out_tdata[DATA_WIDTH-1:0]), out_tuser);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          results_due--;
          if (out_tdata[DATA_WIDTH-1:0] !== want.value) begin
            $error("value mismatch: expected %0d, got %0d",
                   $signed(want.value), $signed(out_tdata[DATA_WIDTH-1:0]));
            fail_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(predict_quotient_sum(
          in_tdata[DATA_WIDTH-1:0],
          in_tdata[2*DATA_WIDTH-1:DATA_WIDTH],
          in_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]));
        results_due++;
      end
    end
  end

endmodule

@@ test/checked_divide_then_add_core_test.sv @@
// checked_divide_then_add_core_test: drives requests into the core with random
// gaps and stalls and gives the verdict. Depends on cdta_pkg, the core and
// quotient_sum_checker.
`timescale 1ns / 1ps

module checked_divide_then_add_core_test;
  import cdta_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1330;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // addend, dividend, divisor from the lowest bit up
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // value, zero padded
  logic [OUT_TDATA_W-1:0] out_tdata;
  // status
  logic [STATUS_W-1:0]    out_tuser;
  int                     fail_count;
  int                     results_due;
  int                     cycle_count = 0;
  bit                     send_steady = 1'b0;

  checked_divide_then_add_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  quotient_sum_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_operands(
    input logic [DATA_WIDTH-1:0] addend,
    input logic [DATA_WIDTH-1:0] dividend,
    input logic [DATA_WIDTH-1:0] divisor
  );
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[DATA_WIDTH-1:0]              = addend;
    w[2*DATA_WIDTH-1:DATA_WIDTH]   = dividend;
    w[3*DATA_WIDTH-1:2*DATA_WIDTH] = divisor;
    return w;
  endfunction

  // offer one request after a random gap, valid stays up when the gap is zero
  task automatic send_request(input logic [IN_TDATA_W-1:0] word);
    int gap;
    if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int stall;
    int taken;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // request side and verdict
  initial begin
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] n;
    logic [DATA_WIDTH-1:0] d;
    longint word_max_l;
    longint word_min_l;
    longint d_l;
    longint q_l;
    longint n_l;
    longint edge_l;
    int     sel;
    int     k;
    longint q_cap;

    word_max_l = longint'(WORD_MAX);
    word_min_l = -word_max_l - 1;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero divisor, the overflowing quotient, inexact, sum overflow
    send_request(pack_operands('0, 32'sd5, '0));
    send_request(pack_operands(WORD_MAX, WORD_MIN, '0));
    send_request(pack_operands('0, WORD_MIN, MINUS_ONE));
    send_request(pack_operands(32'sd5, WORD_MIN, MINUS_ONE));
    send_request(pack_operands('0, 32'sd7, 32'sd2));
    send_request(pack_operands('0, -32'sd7, 32'sd2));
    send_request(pack_operands('0, 32'sd6, -32'sd3));
    send_request(pack_operands('0, -32'sd6, -32'sd3));
    send_request(pack_operands(WORD_MAX, 32'sd1, 32'sd1));
    send_request(pack_operands(WORD_MIN, MINUS_ONE, 32'sd1));
    send_request(pack_operands(WORD_MIN, 32'sd1, MINUS_ONE));
    send_request(pack_operands(WORD_MAX, MINUS_ONE, 32'sd1));
    send_request(pack_operands('0, WORD_MIN, 32'sd1));
    send_request(pack_operands('0, WORD_MIN, WORD_MIN));
    send_request(pack_operands('0, WORD_MAX, WORD_MAX));
    send_request(pack_operands('0, WORD_MAX, MINUS_ONE));
    send_request(pack_operands(MINUS_ONE, WORD_MIN, 32'sd2));
    send_request(pack_operands('0, '0, WORD_MIN));
    send_request(pack_operands('0, '0, MINUS_ONE));
    send_request(pack_operands(WORD_MIN, WORD_MAX, WORD_MIN));
    send_request(pack_operands(WORD_MAX, WORD_MAX, 32'sd1));
    send_request(pack_operands(WORD_MIN, WORD_MIN, 32'sd1));
    send_request(pack_operands(MINUS_ONE, MINUS_ONE, MINUS_ONE));

    // random: mostly exact divisions, half of them with addends near the sum limits
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      a = $urandom;
      if (sel < 8) begin
        n = $urandom;
        d = '0;
      end else if (sel < 12) begin
        n = WORD_MIN;
        d = MINUS_ONE;
      end else if (sel < 35) begin
        n = $urandom;
        d = $urandom;
      end else begin
        if ($urandom_range(0, 9) < 4) begin
          d_l = $urandom_range(1, 16);
        end else begin
          k = $urandom_range(1, DATA_WIDTH - 1);
          d_l = $urandom_range(1, 32'd1 << k);
        end
        q_cap = (longint'(1) << (DATA_WIDTH - 1)) / d_l;
        q_l = $urandom_range(0, int'(q_cap));
        if ($urandom_range(0, 1)) d_l = -d_l;
        if ($urandom_range(0, 1)) q_l = -q_l;
        n_l = q_l * d_l;
        if (n_l > word_max_l) begin
          n_l = -n_l;
          q_l = -q_l;
        end
        n = n_l[DATA_WIDTH-1:0];
        d = d_l[DATA_WIDTH-1:0];
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
          k = $urandom_range(0, DATA_WIDTH - 1);
          a = a >> k;
          if ($urandom_range(0, 1)) a = -a;
        end else if (sel != 1) begin
          edge_l = (q_l >= 0) ? (word_max_l - q_l) : (word_min_l - q_l);
          edge_l = edge_l + longint'($urandom_range(0, 2)) - 1;
          a = edge_l[DATA_WIDTH-1:0];
        end
      end
      send_request(pack_operands(a, n, d));
    end
    in_tvalid <= 1'b0;

    // drain, then leave room for stray results
    do @(posedge clk); while (results_due != 0);
    repeat (DATA_WIDTH + 16) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
